// ----- rtl/core/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared constants, codes and controller/datapath structs of the slot
// allocator with tail trimming.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = 8;   // slot index width, fixed by the word fields
  localparam int CNT_W = 9;   // counts 0 .. SLOTS

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic load_req;    // latch the request word, reset the result
    logic alloc_rd;    // pop: read the stack top, shrink the depth
    logic alloc_new;   // grant the slot at the top, raise the top
    logic alloc_take;  // popped entry is on the RAM read data
    logic set_full;
    logic set_bad;
    logic push;        // push the released index onto the free list
    logic top_dec;
    logic clear;
    logic walk_step;   // trim one free slot off the top
    logic scan_start;
    logic scan_step;   // compaction pass over the free list
    logic scan_end;
    logic emit;        // load the result word
  } sta_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_bad;
    logic       idx_is_top;
    logic       depth_nz;
    logic       store_full;
    logic       walk_more;
    logic       scan_done;
    logic       out_busy;
  } sta_stat_t;

endpackage

// ----- rtl/core/sta_if.sv -----
// ----------------------------------------------------------------------------
// sta_req_if / sta_rsp_if
// Valid/ready channels of the slot allocator: request and result words.
// ----------------------------------------------------------------------------
interface sta_req_if import sta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, mode, slot_index, input ready);
  modport sink   (input valid, mode, slot_index, output ready);
endinterface

interface sta_rsp_if import sta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic [1:0]       status;
  logic [CNT_W-1:0] slot_top;

  modport source (output valid, granted_index, status, slot_top, input ready);
  modport sink   (input valid, granted_index, status, slot_top, output ready);
endinterface

// ----- rtl/core/sta_ram.sv -----
// ----------------------------------------------------------------------------
// sta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sta_ctrl.sv -----
// ----------------------------------------------------------------------------
// sta_ctrl
// Sequencer of the slot allocator: decode, pop, trim walk, compaction, reply.
// ----------------------------------------------------------------------------
module sta_ctrl import sta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  sta_stat_t stat,
  output sta_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (stat.mode)
          MODE_ALLOC: begin
            if (stat.depth_nz) begin
              cmd.alloc_rd = 1'b1;
              state_next   = S_POP;
            end else if (!stat.store_full) begin
              cmd.alloc_new = 1'b1;
            end else begin
              cmd.set_full = 1'b1;
            end
          end
          MODE_RELEASE: begin
            if (stat.idx_bad) begin
              cmd.set_bad = 1'b1;
            end else if (stat.idx_is_top) begin
              cmd.top_dec = 1'b1;
              state_next  = S_WALK;
            end else begin
              cmd.push = 1'b1;
            end
          end
          MODE_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd.alloc_take = 1'b1;
        state_next     = S_FINISH;
      end
      S_WALK: begin
        if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.scan_end = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/sta_dp.sv -----
// ----------------------------------------------------------------------------
// sta_dp
// Datapath: top and depth counters, free marks, free list RAM, compaction
// pointers and the result register.
// Free marks sit in a RAM of their own. A slot's mark is written when the slot
// is appended at the top, so marks at or above the top are never read and
// neither reset nor clear has to sweep them.
// ----------------------------------------------------------------------------
module sta_dp import sta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  sta_cmd_t         cmd,
  output sta_stat_t        stat,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_index,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_granted,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_top
);

  logic [CNT_W-1:0] top_count;
  logic [CNT_W-1:0] free_depth;
  logic [1:0]       req_mode;
  logic [IDX_W-1:0] req_idx;
  logic [IDX_W-1:0] res_granted;
  logic [1:0]       res_status;
  logic [CNT_W-1:0] rd_pos;
  logic [CNT_W-1:0] wr_pos;
  logic             rd_valid;

  logic [CNT_W-1:0] top_m1;
  logic [CNT_W-1:0] top_m2;
  logic [CNT_W-1:0] depth_m1;
  logic             rd_issue;
  logic             keep;
  logic             push_ok;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;
  logic             mark_we;
  logic [IDX_W-1:0] mark_waddr;
  logic             mark_wdata;
  logic [IDX_W-1:0] mark_raddr;
  logic             mark_rdata;

  assign top_m1   = top_count - CNT_W'(1);
  assign top_m2   = top_count - CNT_W'(2);
  assign depth_m1 = free_depth - CNT_W'(1);
  assign rd_issue = (rd_pos < free_depth);
  // entries at or above the new top were trimmed off
  assign keep     = ({1'b0, ram_rdata} < top_count);
  assign push_ok  = cmd.push && (free_depth != CNT_W'(SLOTS));

  assign stat.mode       = req_mode;
  assign stat.idx_bad    = ({1'b0, req_idx} >= top_count) || mark_rdata;
  assign stat.idx_is_top = ({1'b0, req_idx} == top_m1);
  assign stat.depth_nz   = (free_depth != '0);
  assign stat.store_full = (top_count == CNT_W'(SLOTS));
  assign stat.walk_more  = (top_count != '0) && mark_rdata;
  assign stat.scan_done  = !rd_issue && !rd_valid;
  assign stat.out_busy   = out_valid && !out_ready;

  assign ram_we    = push_ok || (cmd.scan_step && rd_valid && keep);
  assign ram_waddr = push_ok ? free_depth[IDX_W-1:0] : wr_pos[IDX_W-1:0];
  assign ram_wdata = push_ok ? req_idx : ram_rdata;
  assign ram_raddr = cmd.alloc_rd ? depth_m1[IDX_W-1:0] : rd_pos[IDX_W-1:0];

  // mark of the requested slot is read at the accept edge; during the trim
  // walk the read runs one slot ahead of the top as it drops
  assign mark_we    = cmd.alloc_new || push_ok || cmd.alloc_take;
  assign mark_waddr = cmd.alloc_take ? ram_rdata :
                      (cmd.alloc_new ? top_count[IDX_W-1:0] : req_idx);
  assign mark_wdata = push_ok;
  assign mark_raddr = cmd.load_req ? in_index : top_m2[IDX_W-1:0];

  sta_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_free_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sta_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_free_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode    <= in_mode;
      req_idx     <= in_index;
      res_granted <= '0;
      res_status  <= ST_OK;
    end
    if (cmd.alloc_new) begin
      res_granted <= top_count[IDX_W-1:0];
    end
    if (cmd.alloc_take) begin
      res_granted <= ram_rdata;
    end
    if (cmd.set_full) begin
      res_status <= ST_FULL;
    end
    if (cmd.set_bad) begin
      res_status <= ST_BAD;
    end
    if (cmd.scan_start) begin
      rd_pos <= '0;
      wr_pos <= '0;
    end
    if (cmd.scan_step) begin
      if (rd_issue) begin
        rd_pos <= rd_pos + CNT_W'(1);
      end
      if (rd_valid && keep) begin
        wr_pos <= wr_pos + CNT_W'(1);
      end
    end
    if (cmd.emit) begin
      out_granted <= res_granted;
      out_status  <= res_status;
      out_top     <= top_count;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count  <= '0;
      free_depth <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.alloc_rd) begin
        free_depth <= depth_m1;
      end
      if (cmd.alloc_new) begin
        top_count <= top_count + CNT_W'(1);
      end
      if (push_ok) begin
        free_depth <= free_depth + CNT_W'(1);
      end
      if (cmd.top_dec) begin
        top_count <= top_m1;
      end
      if (cmd.walk_step) begin
        top_count <= top_m1;
      end
      if (cmd.clear) begin
        top_count  <= '0;
        free_depth <= '0;
      end
      if (cmd.scan_start) begin
        rd_valid <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_valid <= rd_issue;
      end
      if (cmd.scan_end) begin
        free_depth <= wr_pos;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/slot_allocator_tail_trim_unit.sv -----
// ----------------------------------------------------------------------------
// slot_allocator_tail_trim_unit
// Slot allocator with a LIFO free list; releasing the topmost slot trims
// every free slot off the top and compacts the free list.
//
//   channel  dir  fields                               handshake
//   req      in   mode[1:0], slot_index[7:0]           valid/ready
//   rsp      out  granted_index[7:0], status[1:0],     valid/ready
//                 slot_top[8:0]
//
// Allocate from top, clear, bad release, release below the top, unused mode:
// decode, then finish; allocate from the free list adds a pop step
// (registered RAM read). Release of the top slot adds the trim walk over the
// free slots at the top and a compaction pass over the free list RAM.
// One word in flight; req is taken while the previous result word still
// waits on rsp, and the finish step stalls until that word is taken.
// Synchronous reset empties the store.
// ----------------------------------------------------------------------------
module slot_allocator_tail_trim_unit import sta_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  sta_req_if.sink   req,
  sta_rsp_if.source rsp
);

  sta_cmd_t  cmd;
  sta_stat_t stat;

  sta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sta_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (req.mode),
    .in_index    (req.slot_index),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_granted (rsp.granted_index),
    .out_status  (rsp.status),
    .out_top     (rsp.slot_top)
  );

  // one word in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  a_full_reply: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |->
      (rsp.granted_index == '0 && rsp.slot_top == CNT_W'(SLOTS)))
    else $error("full reply inconsistent");

  a_bad_reply: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_BAD) |-> (rsp.granted_index == '0))
    else $error("bad release reply carries a grant");

  a_emit_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (rsp.valid && req.ready))
    else $error("result not presented after emit");

endmodule
